@@ rtl/tccw_pkg.sv @@
// Shared types, character codes and a helper function for the text console cell writer.
package tccw_pkg;

    localparam int CELL_W    = 32;
    localparam int CHAR_W    = 8;
    localparam int TAB_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int SEQ_W     = 3;

    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [TAB_W-1:0] TAB_RESET = 5'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SERIAL_EN = 2'd0,
        CFG_SCREEN_EN = 2'd1,
        CFG_TAB_SIZE  = 2'd2
    } t_cfg_index;

    // Length of a UTF-8 sequence from the lead bits of its first byte.
    function automatic logic [SEQ_W-1:0] lead_length(input logic [CHAR_W-1:0] c);
        logic [SEQ_W-1:0] len;
        begin
            if (!c[5]) begin
                len = 3'd2;
            end else if (!c[4]) begin
                len = 3'd3;
            end else if (!c[3]) begin
                len = 3'd4;
            end else if (!c[2]) begin
                len = 3'd5;
            end else begin
                len = 3'd6;
            end
            return len;
        end
    endfunction

endpackage

@@ rtl/tccw_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module tccw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/text_console_cell_writer_top.sv @@
// Top level of the text console cell writer: cursor, scrolling, UTF-8 packing and serial mirror.
//
// One character byte enters per item on the input channel (i_valid, o_stall) and
// produces one to four result items on the output channel (o_valid, i_stall): one
// per serial byte, or a single one when no serial byte is sent. o_last marks the
// final result item of a character. Configuration registers are written through
// i_cfg_valid / o_cfg_ready, which is always ready, and should only be written while
// the block is idle.
// A plain character passes from acceptance to its first result item through the
// accept cycle, a cell read, the read-modify-write of the cell and the output
// register; further result items follow, each once the one before has been taken.
// A character that finds the cursor below the last row with the screen enabled
// first scrolls the screen: it moves every row one up through the single read
// port, with a read state and a write state per cell, and clears the bottom row. The
// next item is accepted only after the last result item of the current one has been
// taken. While the receiver stalls, the result item holds and no input is taken.
// After reset every cell of the store is cleared before the first item is
// accepted; configuration writes are taken during that pass.
module text_console_cell_writer_top #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_serial_valid,
    output logic [7:0]  o_serial_byte,
    output logic        o_cell_write,
    output logic [4:0]  o_cell_row,
    output logic [6:0]  o_cell_col,
    output logic [31:0] o_cell_value,
    output logic        o_scrolled,
    output logic        o_line_wrapped,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_col,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    localparam int NCELL = ROWS * COLS;
    localparam int AW    = $clog2(NCELL);
    localparam int TOP   = (ROWS - 1) * COLS;
    localparam int XW    = $clog2(COLS + 32);
    localparam int CXW   = $clog2(COLS);
    localparam int YW    = $clog2(ROWS + 1);
    localparam int WRAPS = (COLS + 30) / COLS;
    localparam int CW    = tccw_pkg::CELL_W;
    localparam int SW    = tccw_pkg::SEQ_W;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_SCR_RD,
        S_SCR_WR,
        S_MOD,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [AW-1:0]                   r_ptr;
    logic [tccw_pkg::CHAR_W-1:0]     r_c;
    logic [CXW-1:0]                  r_cx;
    logic [YW-1:0]                   r_cy;
    logic                            r_sa;
    logic [SW-1:0]                   r_sr;
    logic [SW-1:0]                   r_st;
    logic                            r_cw;
    logic [YW-1:0]                   r_crow;
    logic [CXW-1:0]                  r_ccol;
    logic [CW-1:0]                   r_cval;
    logic                            r_scr;
    logic                            r_wrap;
    logic [1:0]                      r_k;
    logic [1:0]                      r_klast;
    logic                            r_ser_en;
    logic                            r_scr_en;
    logic [tccw_pkg::TAB_W-1:0]      r_tab;

    logic [CXW-1:0]                  n_cx;
    logic [YW-1:0]                   n_cy;
    logic                            n_sa;
    logic [SW-1:0]                   n_sr;
    logic [SW-1:0]                   n_st;
    logic                            n_cw;
    logic [CW-1:0]                   n_cval;
    logic                            n_wrap;
    logic [1:0]                      n_klast;

    logic [AW-1:0]                   cell_addr;
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [CW-1:0]                   ram_wdata;
    logic [AW-1:0]                   ram_raddr;
    logic [CW-1:0]                   ram_rdata;
    logic                            first;
    logic                            ptr_in_top;

    tccw_ram #(
        .WIDTH (CW),
        .DEPTH (NCELL)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cell_addr  = AW'(32'(r_cy) * COLS + 32'(r_cx));
    assign ptr_in_top = r_ptr < AW'(TOP);

    // Cell update and cursor movement for the character held in r_c.
    always_comb begin
        logic [XW-1:0] x;
        logic [SW-1:0] pos;
        x      = XW'(r_cx);
        pos    = '0;
        n_cy   = r_cy;
        n_sa   = r_sa;
        n_sr   = r_sr;
        n_st   = r_st;
        n_cw   = 1'b0;
        n_cval = ram_rdata;
        n_wrap = 1'b0;
        if (r_scr_en) begin
            if (r_c == tccw_pkg::CH_NL) begin
                x = XW'(COLS);
            end else if (r_c == tccw_pkg::CH_TAB) begin
                x = x + XW'(r_tab);
            end else begin
                if (r_c[7] && !r_sa) begin
                    n_st = tccw_pkg::lead_length(r_c);
                    n_sr = n_st;
                    n_sa = 1'b1;
                end
                if (n_sa) begin
                    pos = n_st - n_sr;
                    if (pos < 3'd4) begin
                        n_cw = 1'b1;
                        case (pos[1:0])
                            2'd0: n_cval = {24'b0, r_c};
                            2'd1: n_cval = {ram_rdata[31:16], r_c, ram_rdata[7:0]};
                            2'd2: n_cval = {ram_rdata[31:24], r_c, ram_rdata[15:0]};
                            default: n_cval = {r_c, ram_rdata[23:0]};
                        endcase
                    end
                    if (n_sr != '0) begin
                        n_sr = n_sr - SW'(1);
                    end
                    if (n_sr == '0) begin
                        x    = x + XW'(1);
                        n_st = '0;
                        n_sa = 1'b0;
                    end
                end else begin
                    n_cval = {24'b0, r_c};
                    x      = x + XW'(1);
                    n_cw   = 1'b1;
                end
            end
            for (int i = 0; i < WRAPS; i++) begin
                if (x >= XW'(COLS)) begin
                    x = x - XW'(COLS);
                    if (n_cy < YW'(ROWS)) begin
                        n_cy = n_cy + YW'(1);
                    end
                    n_wrap = 1'b1;
                end
            end
        end
        n_cx = CXW'(x);
    end

    always_comb begin
        n_klast = 2'd0;
        if (r_ser_en) begin
            if (r_c == tccw_pkg::CH_NL) begin
                n_klast = 2'd1;
            end else if (r_c == tccw_pkg::CH_TAB) begin
                n_klast = 2'd3;
            end
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = '0;
        ram_raddr = cell_addr;
        case (r_state)
            S_INIT: begin
                ram_we = 1'b1;
            end
            S_SCR_RD: begin
                ram_raddr = ptr_in_top ? AW'(32'(r_ptr) + COLS) : r_ptr;
            end
            S_SCR_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ptr_in_top ? ram_rdata : '0;
            end
            S_MOD: begin
                ram_we    = n_cw;
                ram_waddr = cell_addr;
                ram_wdata = n_cval;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ptr    <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_sa     <= 1'b0;
            r_sr     <= '0;
            r_st     <= '0;
            r_k      <= '0;
            r_klast  <= '0;
            r_ser_en <= 1'b0;
            r_scr_en <= 1'b0;
            r_tab    <= tccw_pkg::TAB_RESET;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tccw_pkg::CFG_SERIAL_EN: r_ser_en <= i_cfg_data[0];
                    tccw_pkg::CFG_SCREEN_EN: r_scr_en <= i_cfg_data[0];
                    tccw_pkg::CFG_TAB_SIZE:  r_tab    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_INIT: begin
                    if (r_ptr == AW'(NCELL - 1)) begin
                        r_ptr   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_c     <= i_char_byte;
                        r_scr   <= 1'b0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_scr_en && r_cy >= YW'(ROWS)) begin
                        r_ptr   <= '0;
                        r_state <= S_SCR_RD;
                    end else begin
                        r_state <= S_MOD;
                    end
                end
                S_SCR_RD: begin
                    r_state <= S_SCR_WR;
                end
                S_SCR_WR: begin
                    if (r_ptr == AW'(NCELL - 1)) begin
                        r_ptr   <= '0;
                        r_cy    <= YW'(ROWS - 1);
                        r_scr   <= 1'b1;
                        r_state <= S_CHECK;
                    end else begin
                        r_ptr   <= r_ptr + AW'(1);
                        r_state <= S_SCR_RD;
                    end
                end
                S_MOD: begin
                    r_cx    <= n_cx;
                    r_cy    <= n_cy;
                    r_sa    <= n_sa;
                    r_sr    <= n_sr;
                    r_st    <= n_st;
                    r_cw    <= n_cw;
                    r_crow  <= r_cy;
                    r_ccol  <= r_cx;
                    r_cval  <= n_cval;
                    r_wrap  <= n_wrap;
                    r_k     <= 2'd0;
                    r_klast <= n_klast;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if (r_k == r_klast) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign first       = (r_k == 2'd0);
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_serial_byte = '0;
        if (r_ser_en) begin
            if (r_c == tccw_pkg::CH_NL) begin
                o_serial_byte = first ? tccw_pkg::CH_CR : tccw_pkg::CH_LF;
            end else if (r_c == tccw_pkg::CH_TAB) begin
                o_serial_byte = tccw_pkg::CH_SPACE;
            end else begin
                o_serial_byte = r_c;
            end
        end
    end

    assign o_serial_valid = r_ser_en;
    assign o_cell_write   = first && r_cw;
    assign o_cell_row     = (first && r_cw) ? 5'(r_crow) : 5'd0;
    assign o_cell_col     = (first && r_cw) ? 7'(r_ccol) : 7'd0;
    assign o_cell_value   = (first && r_cw) ? r_cval : '0;
    assign o_scrolled     = first && r_scr;
    assign o_line_wrapped = first && r_wrap;
    assign o_cursor_row   = 5'(r_cy);
    assign o_cursor_col   = 7'(r_cx);
    assign o_last         = (r_k == r_klast);

endmodule

@@ rtl/tccw_checker.sv @@
// Port-level assertions for the text console cell writer and their binding to the top level.
module tccw_assertions (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        o_stall,
    input logic        i_stall,
    input logic        o_serial_valid,
    input logic [7:0]  o_serial_byte,
    input logic        o_cell_write,
    input logic [31:0] o_cell_value,
    input logic        o_scrolled,
    input logic        o_line_wrapped,
    input logic        o_last
);

    // No new character is taken while a result item is on offer.
    a_no_accept_during_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("Input accepted while a result item is pending.");

    a_stalled_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_serial_byte) && $stable(o_cell_value)
            && $stable(o_last))
        else $error("Stalled result item changed.");

    // Without the serial mirror each character gives exactly one result item.
    a_single_result_when_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_serial_valid |-> o_last && o_serial_byte == 8'h00)
        else $error("Silent character gave more than one result item.");

    // Cell, scroll and wrap reports appear on the first result item only.
    a_reports_on_first_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid && !o_cell_write && !o_scrolled
            && !o_line_wrapped)
        else $error("Cell or cursor report repeated after the first result item.");

endmodule

bind text_console_cell_writer_top tccw_assertions u_tccw_checker (.*);

@@ bench/tccw_checker.sv @@
// Checker for the text console cell writer: watches the channels, predicts results, compares.
module tccw_checker #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_char_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_serial_valid,
    input  logic [7:0]  i_serial_byte,
    input  logic        i_cell_write,
    input  logic [4:0]  i_cell_row,
    input  logic [6:0]  i_cell_col,
    input  logic [31:0] i_cell_value,
    input  logic        i_scrolled,
    input  logic        i_line_wrapped,
    input  logic [4:0]  i_cursor_row,
    input  logic [6:0]  i_cursor_col,
    input  logic        i_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    output int          o_pending,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = ROWS * COLS;

    typedef struct packed {
        logic        serial_valid;
        logic [7:0]  serial_byte;
        logic        cell_write;
        logic [4:0]  cell_row;
        logic [6:0]  cell_col;
        logic [31:0] cell_value;
        logic        scrolled;
        logic        line_wrapped;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        last;
    } t_console_out;

    logic [31:0]  screen [CELLS];
    int unsigned  cur_x;
    int unsigned  cur_y;
    bit           seq_on;
    logic [2:0]   seq_left;
    logic [2:0]   seq_len;
    bit           serial_on;
    bit           screen_on;
    logic [4:0]   tab_cols;
    t_console_out due_outs [$];
    t_console_out want;
    int           mismatch_count = 0;

    function automatic void clear_console();
        foreach (screen[k]) screen[k] = '0;
        cur_x     = 0;
        cur_y     = 0;
        seq_on    = 1'b0;
        seq_left  = '0;
        seq_len   = '0;
        serial_on = 1'b0;
        screen_on = 1'b0;
        tab_cols  = tccw_pkg::TAB_RESET;
    endfunction

    function automatic void print_char(input logic [7:0] c);
        logic [7:0]   ser [4];
        int           nser;
        int           nout;
        int           idx;
        int           k;
        logic [2:0]   pos;
        bit           wrote;
        bit           did_scroll;
        bit           did_wrap;
        t_console_out r;
        nser       = 0;
        idx        = 0;
        wrote      = 1'b0;
        did_scroll = 1'b0;
        did_wrap   = 1'b0;
        if (serial_on) begin
            if (c == tccw_pkg::CH_NL) begin
                ser[0] = tccw_pkg::CH_CR;
                ser[1] = tccw_pkg::CH_LF;
                nser   = 2;
            end else if (c == tccw_pkg::CH_TAB) begin
                for (k = 0; k < 4; k++) ser[k] = tccw_pkg::CH_SPACE;
                nser = 4;
            end else begin
                ser[0] = c;
                nser   = 1;
            end
        end
        if (screen_on) begin
            if (cur_y >= ROWS) begin
                cur_y = ROWS - 1;
                for (k = 0; k < CELLS - COLS; k++) screen[k] = screen[k + COLS];
                for (k = CELLS - COLS; k < CELLS; k++) screen[k] = '0;
                did_scroll = 1'b1;
            end
            if (c == tccw_pkg::CH_NL) begin
                cur_x = COLS;
            end else if (c == tccw_pkg::CH_TAB) begin
                cur_x += tab_cols;
            end else begin
                idx = cur_y * COLS + cur_x;
                if (idx >= CELLS) idx = 0;
                if (c[7] && !seq_on) begin
                    casez (c[5:2])
                        4'b0???: seq_len = 3'd2;
                        4'b10??: seq_len = 3'd3;
                        4'b110?: seq_len = 3'd4;
                        4'b1110: seq_len = 3'd5;
                        default: seq_len = 3'd6;
                    endcase
                    seq_left = seq_len;
                    seq_on   = 1'b1;
                end
                if (seq_on) begin
                    pos = seq_len - seq_left;
                    if (pos < 3'd4) begin
                        if (pos == 3'd0) begin
                            screen[idx] = {24'h0, c};
                        end else begin
                            screen[idx][8 * pos +: 8] = c;
                        end
                        wrote = 1'b1;
                    end
                    if (seq_left > 0) seq_left--;
                    if (seq_left == 0) begin
                        cur_x++;
                        seq_len = '0;
                        seq_on  = 1'b0;
                    end
                end else begin
                    screen[idx] = {24'h0, c};
                    cur_x++;
                    wrote = 1'b1;
                end
            end
            while (cur_x >= COLS) begin
                cur_x -= COLS;
                if (cur_y < ROWS) cur_y++;
                did_wrap = 1'b1;
            end
        end
        nout = (nser > 0) ? nser : 1;
        for (k = 0; k < nout; k++) begin
            r              = '0;
            r.serial_valid = (k < nser);
            r.serial_byte  = (k < nser) ? ser[k] : 8'h00;
            if (k == 0) begin
                r.scrolled     = did_scroll;
                r.line_wrapped = did_wrap;
                if (wrote) begin
                    r.cell_write = 1'b1;
                    r.cell_row   = 5'(idx / COLS);
                    r.cell_col   = 7'(idx % COLS);
                    r.cell_value = screen[idx];
                end
            end
            r.cursor_row = cur_y[4:0];
            r.cursor_col = cur_x[6:0];
            r.last       = (k == nout - 1);
            due_outs.push_back(r);
        end
    endfunction

    function automatic void compare_field(input string what, input logic [31:0] exp_val,
                                          input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_console();
            due_outs.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (tccw_pkg::t_cfg_index'(i_cfg_index))
                    tccw_pkg::CFG_SERIAL_EN: serial_on = i_cfg_data[0];
                    tccw_pkg::CFG_SCREEN_EN: screen_on = i_cfg_data[0];
                    tccw_pkg::CFG_TAB_SIZE:  tab_cols  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_outs.size() == 0) begin
                    $display("%0t: result item expected none actual serial %0h cell %0h",
                             $time, i_serial_byte, i_cell_value);
                    mismatch_count++;
                end else begin
                    want = due_outs.pop_front();
                    compare_field("serial_valid", want.serial_valid, i_serial_valid);
                    compare_field("serial_byte", want.serial_byte, i_serial_byte);
                    compare_field("cell_write", want.cell_write, i_cell_write);
                    compare_field("cell_row", want.cell_row, i_cell_row);
                    compare_field("cell_col", want.cell_col, i_cell_col);
                    compare_field("cell_value", want.cell_value, i_cell_value);
                    compare_field("scrolled", want.scrolled, i_scrolled);
                    compare_field("line_wrapped", want.line_wrapped, i_line_wrapped);
                    compare_field("cursor_row", want.cursor_row, i_cursor_row);
                    compare_field("cursor_col", want.cursor_col, i_cursor_col);
                    compare_field("last", want.last, i_last);
                end
            end
            if (i_in_valid && !i_in_stall) print_char(i_char_byte);
        end
        o_pending    <= due_outs.size();
        o_fail_count <= mismatch_count;
    end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for the text console cell writer: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int LIMIT = 500 * (2 * ROWS * COLS + 64) * 4 + ROWS * COLS;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_char_byte = 8'h00;
    logic        i_stall     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = tccw_pkg::CFG_SERIAL_EN;
    logic [4:0]  i_cfg_data  = 5'd0;
    logic        o_stall;
    logic        o_valid;
    logic        o_serial_valid;
    logic [7:0]  o_serial_byte;
    logic        o_cell_write;
    logic [4:0]  o_cell_row;
    logic [6:0]  o_cell_col;
    logic [31:0] o_cell_value;
    logic        o_scrolled;
    logic        o_line_wrapped;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_col;
    logic        o_last;
    logic        o_cfg_ready;
    int          pending_results;
    int          fail_count;
    bit          idle_on     = 1'b1;
    int          stall_left  = 0;
    int          cycle_count = 0;

    logic [7:0] directed_text [25] = '{
        8'h00, 8'h09, 8'h0A,
        8'h80, 8'h7F,
        8'hE2, 8'h0A, 8'h82, 8'h09, 8'hAC,
        8'hF0, 8'h9F, 8'h98, 8'h80,
        8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
        8'hFF, 8'hBF, 8'h80, 8'h80, 8'h80, 8'hFF
    };

    text_console_cell_writer_top #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_byte    (i_char_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_serial_valid (o_serial_valid),
        .o_serial_byte  (o_serial_byte),
        .o_cell_write   (o_cell_write),
        .o_cell_row     (o_cell_row),
        .o_cell_col     (o_cell_col),
        .o_cell_value   (o_cell_value),
        .o_scrolled     (o_scrolled),
        .o_line_wrapped (o_line_wrapped),
        .o_cursor_row   (o_cursor_row),
        .o_cursor_col   (o_cursor_col),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    tccw_checker #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_char_byte    (i_char_byte),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_serial_valid (o_serial_valid),
        .i_serial_byte  (o_serial_byte),
        .i_cell_write   (o_cell_write),
        .i_cell_row     (o_cell_row),
        .i_cell_col     (o_cell_col),
        .i_cell_value   (o_cell_value),
        .i_scrolled     (o_scrolled),
        .i_line_wrapped (o_line_wrapped),
        .i_cursor_row   (o_cursor_row),
        .i_cursor_col   (o_cursor_col),
        .i_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending_results),
        .o_fail_count   (fail_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] c);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_byte <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_quiet(input int settle);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic cfg_write(input tccw_pkg::t_cfg_index idx, input logic [4:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_settings(input bit ser_on, input bit scr_on, input logic [4:0] tab);
        cfg_write(tccw_pkg::CFG_SERIAL_EN, {4'b0, ser_on});
        cfg_write(tccw_pkg::CFG_SCREEN_EN, {4'b0, scr_on});
        cfg_write(tccw_pkg::CFG_TAB_SIZE, tab);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly printable text and sequences shaped after UTF-8, with line breaks, tabs
    // and raw bytes mixed in; a line-heavy chunk weights line breaks more heavily.
    task automatic send_chunk(input int n_items, input bit line_heavy);
        int         sent;
        int         pick;
        int         len;
        int         k;
        logic [7:0] lead;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_char(8'($urandom_range(32, 126)));
                sent++;
            end else if (pick < 60) begin
                len     = $urandom_range(2, 6);
                lead    = 8'($urandom_range(0, 255));
                lead[7] = 1'b1;
                case (len)
                    2:       lead[5]   = 1'b0;
                    3:       lead[5:4] = 2'b10;
                    4:       lead[5:3] = 3'b110;
                    5:       lead[5:2] = 4'b1110;
                    default: lead[5:2] = 4'b1111;
                endcase
                send_char(lead);
                sent++;
                for (k = 1; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_char($urandom_range(0, 1) ? tccw_pkg::CH_NL : tccw_pkg::CH_TAB);
                        sent++;
                    end
                    send_char({2'b10, 6'($urandom_range(0, 63))});
                    sent++;
                end
            end else if (pick < (line_heavy ? 85 : 68)) begin
                send_char(tccw_pkg::CH_NL);
                sent++;
            end else if (pick < (line_heavy ? 90 : 78)) begin
                send_char(tccw_pkg::CH_TAB);
                sent++;
            end else begin
                send_char(8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    initial begin
        int chunk;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With the reset settings both outputs are off.
        send_char(8'h41);
        send_char(tccw_pkg::CH_NL);
        wait_quiet(8);

        apply_settings(1'b1, 1'b1, 5'd4);
        foreach (directed_text[k]) send_char(directed_text[k]);
        wait_quiet(8);

        for (chunk = 0; chunk < 10; chunk++) begin
            case (chunk)
                0: apply_settings(1'b1, 1'b1, 5'd4);
                1: apply_settings(1'b0, 1'b1, 5'd31);
                2: apply_settings(1'b1, 1'b1, 5'd1);
                3: apply_settings(1'b1, 1'b0, 5'd0);
                4: apply_settings(1'b0, 1'b0, 5'd16);
                5: apply_settings(1'b1, 1'b1, 5'd16);
                6: apply_settings(1'b1, 1'b1, 5'd0);
                7: apply_settings(1'b0, 1'b1, 5'd8);
                8: apply_settings(1'b1, 1'b1, 5'd17);
                default: apply_settings(1'b1, 1'b1, 5'($urandom_range(1, 16)));
            endcase
            idle_on <= (chunk == 9) ? 1'b0 : ($urandom_range(0, 3) != 0);
            send_chunk(40, chunk == 1 || chunk == 6);
            wait_quiet((chunk == 9) ? 16 : 8);
        end

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
